// ----- sv/msc_pkg.sv -----
// package for the multi-servo slew controller: sizes, codes and the angle clamp
// no dependencies
`timescale 1ns / 1ps

package msc_pkg;

  localparam int NUM_SERVOS = 8;
  localparam int CH_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  // active count (4 bits) and NUM_SERVOS (up to 16) both fit in five bits
  localparam int CNT_W = 5;

  // input function codes
  localparam logic [2:0] FUNC_ATTACH   = 3'd0;
  localparam logic [2:0] FUNC_DETACH   = 3'd1;
  localparam logic [2:0] FUNC_SET_TGT  = 3'd2;
  localparam logic [2:0] FUNC_SET_IMM  = 3'd3;
  localparam logic [2:0] FUNC_SNAP_ALL = 3'd4;
  localparam logic [2:0] FUNC_TICK     = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_SLEW_RATE  = 3'd0;
  localparam logic [2:0] REG_FLOOR      = 3'd1;
  localparam logic [2:0] REG_CEILING    = 3'd2;
  localparam logic [2:0] REG_ACTIVE_CNT = 3'd3;
  localparam logic [2:0] REG_PIN_MASK   = 3'd4;

  localparam logic [15:0] SLEW_RATE_RESET = 16'd60;
  localparam logic [7:0]  FLOOR_RESET     = 8'd0;
  localparam logic [7:0]  CEILING_RESET   = 8'd180;
  localparam logic [3:0]  ACTIVE_RESET    = 4'd8;
  localparam logic [7:0]  PIN_MASK_RESET  = 8'd255;
  localparam logic [7:0]  ANGLE_RESET     = 8'd90;

  // step = floor(p / 1000) for p < 2^18 as (p * RECIP_M) >> RECIP_SHIFT
  localparam logic [18:0] RECIP_M     = 19'd268436;
  localparam int          RECIP_SHIFT = 28;
  // rate * elapsed at or above this gives a step of 255 or more
  localparam logic [33:0] SAT_PROD    = 34'd255000;
  localparam logic [7:0]  STEP_MAX    = 8'd255;

  function automatic logic [7:0] clamp_angle(input logic signed [15:0] a,
                                             input logic [7:0] lo,
                                             input logic [7:0] hi);
    logic signed [15:0] lo_s;
    logic signed [15:0] hi_s;
    lo_s = signed'({8'b0, lo});
    hi_s = signed'({8'b0, hi});
    if (a < lo_s) begin
      return lo;
    end else if (a > hi_s) begin
      return hi;
    end else begin
      return a[7:0];
    end
  endfunction

endpackage

// ----- sv/multi_servo_slew_controller_unit.sv -----
// top level of the multi-servo slew controller: per-servo state, sequencer and
// one shared multiplier for the slew step; uses msc_pkg
`timescale 1ns / 1ps
// attach, detach, set target and set immediate hold busy through exec and flush;
// snap all walks every servo slot in snap; a tick scans each slot and takes a
// moving servo through mul1, mul2 and move (the multiplier is used twice per move:
// rate times elapsed, then divide by 1000); each result is strobed when the next is
// found, the last with last_write from flush; the receiver cannot stall them
// reset (rst, synchronous) restores the register defaults, detaches all servos,
// sets current and target angles to 90 and last move times to zero

module multi_servo_slew_controller_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          func,
  input  logic [2:0]          servo_index,
  input  logic signed [15:0]  angle_request,
  input  logic [31:0]         time_ms,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [15:0]         wr_data,
  output logic                result_strobe,
  output logic [2:0]          servo_out,
  output logic [7:0]          angle_out,
  output logic                last_write
);
  import msc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SNAP  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_MUL1  = 3'd4;
  localparam logic [2:0] ST_MUL2  = 3'd5;
  localparam logic [2:0] ST_MOVE  = 3'd6;
  localparam logic [2:0] ST_FLUSH = 3'd7;

  // configuration
  logic [15:0] slew_rate;
  logic [7:0]  angle_floor;
  logic [7:0]  angle_ceiling;
  logic [3:0]  active_count;
  logic [7:0]  pin_valid_mask;

  // per-servo state
  logic        attached [NUM_SERVOS];
  logic [7:0]  cur_ang  [NUM_SERVOS];
  logic [7:0]  tgt_ang  [NUM_SERVOS];
  logic [31:0] last_t   [NUM_SERVOS];

  // latched item
  logic [2:0]         func_q;
  logic [2:0]         idx_q;
  logic signed [15:0] req_q;
  logic [31:0]        now_q;

  logic [2:0]      state;
  logic [CH_W-1:0] ch;
  logic [31:0]     elapsed;
  logic            sat;
  logic [33:0]     prod;
  logic [7:0]      step;

  // one result held back until we know whether it is the last of the item
  logic            pend_v;
  logic [CH_W-1:0] pend_ch;
  logic [7:0]      pend_ang;

  // shared multiplier
  logic [18:0] mul_a;
  logic [17:0] mul_b;
  logic [36:0] mul_p;

  logic [CNT_W-1:0] n_use;
  logic [CH_W-1:0]  idx_ch;
  logic             idx_ok;
  logic             ch_ok;
  logic             ch_last;
  logic [7:0]       cur_sel;
  logic [7:0]       tgt_sel;
  logic [31:0]      last_sel;
  logic [31:0]      elapsed_now;
  logic             need_move;
  logic [7:0]       req_clamped;
  logic [7:0]       snap_ang;
  logic [8:0]       sum9;
  logic [7:0]       dn;
  logic [7:0]       new_ang;
  logic [7:0]       q;

  assign busy = (state != ST_IDLE);

  always_comb begin
    if ({1'b0, active_count} > CNT_W'(NUM_SERVOS)) begin
      n_use = CNT_W'(NUM_SERVOS);
    end else begin
      n_use = CNT_W'(active_count);
    end
  end

  assign idx_ch  = CH_W'(idx_q);
  assign idx_ok  = (CNT_W'(idx_q) < n_use);
  assign ch_ok   = (CNT_W'(ch) < n_use);
  assign ch_last = (ch == CH_W'(NUM_SERVOS - 1));

  assign cur_sel  = cur_ang[ch];
  assign tgt_sel  = tgt_ang[ch];
  assign last_sel = last_t[ch];
  assign elapsed_now = now_q - last_sel;
  // zero elapsed moves only a servo whose last move time is zero
  assign need_move = ch_ok && attached[ch] && (cur_sel != tgt_sel) &&
                     !((elapsed_now == 32'd0) && (last_sel != 32'd0));

  assign req_clamped = clamp_angle(req_q, angle_floor, angle_ceiling);
  assign snap_ang    = clamp_angle(signed'({8'b0, tgt_sel}), angle_floor, angle_ceiling);

  always_comb begin
    if (state == ST_MUL2) begin
      mul_a = RECIP_M;
      mul_b = prod[17:0];
    end else begin
      mul_a = {3'b0, slew_rate};
      mul_b = elapsed[17:0];
    end
  end
  assign mul_p = {18'b0, mul_a} * {19'b0, mul_b};
  assign q = mul_p[RECIP_SHIFT +: 8];

  always_comb begin
    sum9 = {1'b0, cur_sel} + {1'b0, step};
    dn   = (cur_sel > step) ? (cur_sel - step) : 8'd0;
    if (cur_sel < tgt_sel) begin
      new_ang = (sum9 > {1'b0, tgt_sel}) ? tgt_sel : sum9[7:0];
    end else begin
      new_ang = (dn < tgt_sel) ? tgt_sel : dn;
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      slew_rate      <= SLEW_RATE_RESET;
      angle_floor    <= FLOOR_RESET;
      angle_ceiling  <= CEILING_RESET;
      active_count   <= ACTIVE_RESET;
      pin_valid_mask <= PIN_MASK_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SLEW_RATE:  slew_rate      <= wr_data;
        REG_FLOOR:      angle_floor    <= wr_data[7:0];
        REG_CEILING:    angle_ceiling  <= wr_data[7:0];
        REG_ACTIVE_CNT: active_count   <= wr_data[3:0];
        REG_PIN_MASK:   pin_valid_mask <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // item latch and slew datapath registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_q <= func;
      idx_q  <= servo_index;
      req_q  <= angle_request;
      now_q  <= time_ms;
    end
    if (state == ST_SCAN) begin
      elapsed <= elapsed_now;
      sat     <= (elapsed_now[31:18] != 14'd0) && (slew_rate != 16'd0);
    end
    if (state == ST_MUL1) begin
      prod <= mul_p[33:0];
    end
    if (state == ST_MUL2) begin
      if (sat || (prod >= SAT_PROD)) begin
        step <= STEP_MAX;
      end else if (q == 8'd0) begin
        step <= 8'd1;
      end else begin
        step <= q;
      end
    end
  end

  // sequencer, servo state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ch            <= '0;
      pend_v        <= 1'b0;
      result_strobe <= 1'b0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        attached[i] <= 1'b0;
        cur_ang[i]  <= ANGLE_RESET;
        tgt_ang[i]  <= ANGLE_RESET;
        last_t[i]   <= 32'd0;
      end
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state  <= ST_EXEC;
            ch     <= '0;
            pend_v <= 1'b0;
          end
        end
        ST_EXEC: begin
          case (func_q)
            FUNC_ATTACH: begin
              state <= ST_FLUSH;
              for (int i = 0; i < NUM_SERVOS; i++) begin
                if ((CNT_W'(i) < n_use) && (i < 8) && pin_valid_mask[3'(i)]) begin
                  attached[i] <= 1'b1;
                end
              end
            end
            FUNC_DETACH: begin
              state <= ST_FLUSH;
              for (int i = 0; i < NUM_SERVOS; i++) begin
                if (CNT_W'(i) < n_use) begin
                  attached[i] <= 1'b0;
                end
              end
            end
            FUNC_SET_TGT: begin
              state <= ST_FLUSH;
              if (idx_ok) begin
                tgt_ang[idx_ch] <= req_clamped;
              end
            end
            FUNC_SET_IMM: begin
              state <= ST_FLUSH;
              if (idx_ok && attached[idx_ch]) begin
                cur_ang[idx_ch] <= req_clamped;
                tgt_ang[idx_ch] <= req_clamped;
                pend_v   <= 1'b1;
                pend_ch  <= idx_ch;
                pend_ang <= req_clamped;
              end
            end
            FUNC_SNAP_ALL: state <= ST_SNAP;
            FUNC_TICK:     state <= ST_SCAN;
            default:       state <= ST_FLUSH;
          endcase
        end
        ST_SNAP: begin
          if (ch_ok && attached[ch]) begin
            cur_ang[ch] <= snap_ang;
            tgt_ang[ch] <= snap_ang;
            if (pend_v) begin
              result_strobe <= 1'b1;
              servo_out     <= 3'(pend_ch);
              angle_out     <= pend_ang;
              last_write    <= 1'b0;
            end
            pend_v   <= 1'b1;
            pend_ch  <= ch;
            pend_ang <= snap_ang;
          end
          ch <= ch + 1'b1;
          if (ch_last) begin
            state <= ST_FLUSH;
          end
        end
        ST_SCAN: begin
          if (need_move) begin
            state <= ST_MUL1;
          end else begin
            ch <= ch + 1'b1;
            if (ch_last) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_MOVE;
        ST_MOVE: begin
          cur_ang[ch] <= new_ang;
          last_t[ch]  <= now_q;
          if (pend_v) begin
            result_strobe <= 1'b1;
            servo_out     <= 3'(pend_ch);
            angle_out     <= pend_ang;
            last_write    <= 1'b0;
          end
          pend_v   <= 1'b1;
          pend_ch  <= ch;
          pend_ang <= new_ang;
          ch <= ch + 1'b1;
          state <= ch_last ? ST_FLUSH : ST_SCAN;
        end
        ST_FLUSH: begin
          // the held beat is the final one of the item
          if (pend_v) begin
            result_strobe <= 1'b1;
            servo_out     <= 3'(pend_ch);
            angle_out     <= pend_ang;
            last_write    <= 1'b1;
          end
          pend_v <= 1'b0;
          state  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for multi_servo_slew_controller_unit: a directed command table, then
// random command phases under several register settings; depends on msc_pkg and the dut

module testbench;
  import msc_pkg::*;

  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
  localparam int FROM_PREDICTOR = -1;
  localparam int NO_WRITE       = 0;
  localparam int ONE_WRITE      = 1;
  localparam int WATCHDOG       = 1000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int MAX_GAP        = 60;
  localparam int NUM_PHASES     = 7;
  localparam int CMDS_PER_PHASE = 51;

  typedef struct packed {
    logic [2:0] servo;
    logic [7:0] angle;
    logic       last;
  } servo_write_t;

  typedef struct {
    logic [2:0]         func;
    logic [2:0]         idx;
    logic signed [15:0] req;
    logic [31:0]        tms;
    int                 exp_n;
    logic [2:0]         exp_servo;
    logic [7:0]         exp_angle;
  } servo_cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         func = '0;
  logic [2:0]         servo_index = '0;
  logic signed [15:0] angle_request = '0;
  logic [31:0]        time_ms = '0;
  logic               wr_en = 1'b0;
  logic [2:0]         wr_index = '0;
  logic [15:0]        wr_data = '0;
  logic               result_strobe;
  logic [2:0]         servo_out;
  logic [7:0]         angle_out;
  logic               last_write;

  multi_servo_slew_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .servo_index   (servo_index),
    .angle_request (angle_request),
    .time_ms       (time_ms),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .result_strobe (result_strobe),
    .servo_out     (servo_out),
    .angle_out     (angle_out),
    .last_write    (last_write)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // slew tracker: registers and per-servo state
  logic [15:0]           cfg_rate;
  logic [7:0]            cfg_floor;
  logic [7:0]            cfg_ceiling;
  logic [3:0]            cfg_active;
  logic [7:0]            cfg_pins;
  logic [NUM_SERVOS-1:0] attached;
  logic [7:0]            cur_angle [NUM_SERVOS];
  logic [7:0]            tgt_angle [NUM_SERVOS];
  logic [31:0]           moved_at  [NUM_SERVOS];

  servo_write_t pending_writes[$];
  servo_write_t step_writes[$];
  int           mismatches = 0;
  int           writes_checked = 0;
  int           cmds_sent = 0;
  int           settings_used = 0;
  int           quiet_cycles = 0;
  logic         took_item;
  logic [31:0]  now_ms = '0;

  task automatic reset_tracker();
    cfg_rate    = SLEW_RATE_RESET;
    cfg_floor   = FLOOR_RESET;
    cfg_ceiling = CEILING_RESET;
    cfg_active  = ACTIVE_RESET;
    cfg_pins    = PIN_MASK_RESET;
    attached    = '0;
    for (int i = 0; i < NUM_SERVOS; i++) begin
      cur_angle[i] = ANGLE_RESET;
      tgt_angle[i] = ANGLE_RESET;
      moved_at[i]  = '0;
    end
  endtask

  function automatic logic [7:0] clamp_req(input logic signed [15:0] a);
    int v;
    v = a;
    if (v < int'(cfg_floor)) return cfg_floor;
    if (v > int'(cfg_ceiling)) return cfg_ceiling;
    return a[7:0];
  endfunction

  task automatic emit_write(input int ch, input logic [7:0] ang);
    servo_write_t w;
    w.servo = 3'(ch);
    w.angle = ang;
    w.last  = 1'b0;
    step_writes.push_back(w);
  endtask

  task automatic predict_cmd(input servo_cmd_t c);
    int           n;
    int           cur;
    int           tgt;
    int           step;
    logic [31:0]  elapsed;
    logic [63:0]  prod;
    logic [7:0]   a;
    servo_write_t w;
    step_writes.delete();
    n = (int'(cfg_active) > NUM_SERVOS) ? NUM_SERVOS : int'(cfg_active);
    case (c.func)
      FUNC_ATTACH: begin
        for (int i = 0; i < n; i++) if (cfg_pins[i]) attached[i] = 1'b1;
      end
      FUNC_DETACH: begin
        for (int i = 0; i < n; i++) attached[i] = 1'b0;
      end
      FUNC_SET_TGT: begin
        if (int'(c.idx) < n) tgt_angle[c.idx] = clamp_req(c.req);
      end
      FUNC_SET_IMM: begin
        if (int'(c.idx) < n && attached[c.idx]) begin
          a = clamp_req(c.req);
          cur_angle[c.idx] = a;
          tgt_angle[c.idx] = a;
          emit_write(int'(c.idx), a);
        end
      end
      FUNC_SNAP_ALL: begin
        for (int i = 0; i < n; i++) begin
          if (attached[i]) begin
            a = clamp_req(signed'({8'd0, tgt_angle[i]}));
            cur_angle[i] = a;
            tgt_angle[i] = a;
            emit_write(i, a);
          end
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < n; i++) begin
          cur = cur_angle[i];
          tgt = tgt_angle[i];
          elapsed = c.tms - moved_at[i];
          // no elapsed time only moves a servo whose last move time is zero
          if (attached[i] && cur != tgt && !(elapsed == 0 && moved_at[i] != 0)) begin
            prod = 64'(cfg_rate) * 64'(elapsed);
            prod = prod / 64'd1000;
            step = (prod == 0) ? 1 : ((prod > 64'd255) ? 255 : int'(prod));
            if (cur < tgt) begin
              cur = cur + step;
              if (cur > tgt) cur = tgt;
            end else begin
              cur = (cur > step) ? cur - step : 0;
              if (cur < tgt) cur = tgt;
            end
            cur_angle[i] = 8'(cur);
            moved_at[i]  = c.tms;
            emit_write(i, 8'(cur));
          end
        end
      end
      default: ;
    endcase
    if (step_writes.size() > 0) begin
      w = step_writes.pop_back();
      w.last = 1'b1;
      step_writes.push_back(w);
    end
  endtask

  task automatic check_write();
    servo_write_t want;
    if (pending_writes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected write: servo %0d angle %0d last %0b",
                 servo_out, angle_out, last_write);
    end else begin
      want = pending_writes.pop_front();
      writes_checked++;
      if (servo_out !== want.servo || angle_out !== want.angle || last_write !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("write mismatch: expected servo %0d angle %0d last %0b, got %0d %0d %0b",
                   want.servo, want.angle, want.last, servo_out, angle_out, last_write);
      end
    end
  endtask

  // one clock: a result beat is taken at the edge that ends its strobe cycle
  task automatic clock_step();
    @(posedge clk);
    took_item = start && !busy;
    if (result_strobe) check_write();
    if (took_item || result_strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG);
      $display("testbench: done, errors");
      $finish;
    end
  endtask

  task automatic send_cmd(input servo_cmd_t c, input int idle_pct);
    int gap;
    servo_write_t w;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) clock_step();
    end
    func          <= c.func;
    servo_index   <= c.idx;
    angle_request <= c.req;
    time_ms       <= c.tms;
    start         <= 1'b1;
    do clock_step(); while (!took_item);
    predict_cmd(c);
    if (c.exp_n == FROM_PREDICTOR) begin
      foreach (step_writes[k]) pending_writes.push_back(step_writes[k]);
    end else if (c.exp_n == ONE_WRITE) begin
      w.servo = c.exp_servo;
      w.angle = c.exp_angle;
      w.last  = 1'b1;
      pending_writes.push_back(w);
    end
    cmds_sent++;
  endtask

  // idle the command side until every write is in and the walk is over
  task automatic settle();
    start <= 1'b0;
    while (pending_writes.size() != 0) clock_step();
    repeat (SETTLE_CYCLES) clock_step();
    while (busy) clock_step();
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    clock_step();
    case (idx)
      REG_SLEW_RATE:  cfg_rate    = val;
      REG_FLOOR:      cfg_floor   = val[7:0];
      REG_CEILING:    cfg_ceiling = val[7:0];
      REG_ACTIVE_CNT: cfg_active  = val[3:0];
      REG_PIN_MASK:   cfg_pins    = val[7:0];
      default: ;
    endcase
  endtask

  function automatic servo_cmd_t mk_cmd(input logic [2:0] f, input logic [2:0] idx,
                                        input logic signed [15:0] req, input logic [31:0] tms,
                                        input int exp_n, input logic [2:0] s,
                                        input logic [7:0] a);
    servo_cmd_t c;
    c.func = f;
    c.idx = idx;
    c.req = req;
    c.tms = tms;
    c.exp_n = exp_n;
    c.exp_servo = s;
    c.exp_angle = a;
    return c;
  endfunction

  task automatic roll_cmd(output servo_cmd_t c);
    int pick;
    int r;
    pick = $urandom_range(99);
    r = $urandom_range(99);
    c.idx = 3'($urandom_range(7));
    if (r < 70) c.req = 16'(int'($urandom_range(210)) - 15);
    else if (r < 85) c.req = 16'($urandom_range(180));
    else c.req = 16'($urandom());
    c.tms = $urandom();
    c.exp_n = FROM_PREDICTOR;
    c.exp_servo = '0;
    c.exp_angle = '0;
    if (pick < 40) begin
      c.func = FUNC_TICK;
      r = $urandom_range(99);
      // mostly short steps of time, with repeats, long jumps, wraps and zero
      if (r < 55) now_ms = now_ms + $urandom_range(40, 1);
      else if (r < 70) now_ms = now_ms;
      else if (r < 80) now_ms = now_ms + $urandom_range(6000, 100);
      else if (r < 88) now_ms = $urandom();
      else if (r < 94) now_ms = '0;
      else now_ms = now_ms + $urandom_range(3, 1);
      c.tms = now_ms;
    end
    else if (pick < 65) c.func = FUNC_SET_TGT;
    else if (pick < 75) c.func = FUNC_SET_IMM;
    else if (pick < 81) c.func = FUNC_SNAP_ALL;
    else if (pick < 89) c.func = FUNC_ATTACH;
    else if (pick < 93) c.func = FUNC_DETACH;
    else if (pick < 97) c.func = FUNC_SPARE_6;
    else c.func = FUNC_SPARE_7;
  endtask

  initial begin
    servo_cmd_t  dir_rows[$];
    servo_cmd_t  c;
    logic [15:0] ph_rate;
    logic [7:0]  ph_floor;
    logic [7:0]  ph_ceiling;
    logic [3:0]  ph_active;
    logic [7:0]  ph_pins;
    int          idle_pct;
    int          counted;

    reset_tracker();
    // directed table under reset settings
    dir_rows.push_back(mk_cmd(FUNC_TICK, 3'd0, 16'sd0, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SET_TGT, 3'd0, 16'sd100, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SET_IMM, 3'd0, 16'sd45, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_ATTACH, 3'd0, 16'sd0, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SET_IMM, 3'd0, 16'sh7FFF, 32'd0, ONE_WRITE, 3'd0, 8'd180));
    dir_rows.push_back(mk_cmd(FUNC_SET_IMM, 3'd7, 16'sh8000, 32'hFFFF_FFFF, ONE_WRITE,
                              3'd7, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SET_TGT, 3'd1, 16'sd120, 32'd0, NO_WRITE, 3'd0, 8'd0));
    // first tick at time zero moves one degree
    dir_rows.push_back(mk_cmd(FUNC_TICK, 3'd0, 16'sd0, 32'd0, ONE_WRITE, 3'd1, 8'd91));
    dir_rows.push_back(mk_cmd(FUNC_TICK, 3'd0, 16'sd0, 32'd0, FROM_PREDICTOR, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_TICK, 3'd0, 16'sd0, 32'd500, FROM_PREDICTOR, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SET_TGT, 3'd2, 16'sd10, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SET_TGT, 3'd4, 16'sd170, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_TICK, 3'd0, 16'sd0, 32'd500, FROM_PREDICTOR, 3'd0, 8'd0));
    // same time again after a move: nothing moves
    dir_rows.push_back(mk_cmd(FUNC_TICK, 3'd0, 16'sd0, 32'd500, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_TICK, 3'd0, 16'sd0, 32'hFFFF_FFFF, FROM_PREDICTOR,
                              3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SET_TGT, 3'd3, 16'sd200, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_TICK, 3'd0, 16'sd0, 32'd4, FROM_PREDICTOR, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_DETACH, 3'd0, 16'sd0, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_TICK, 3'd0, 16'sd0, 32'd100, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SET_IMM, 3'd5, 16'sd60, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SPARE_6, 3'd7, 16'sd90, 32'd200, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SPARE_7, 3'd7, 16'sd90, 32'd200, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_ATTACH, 3'd0, 16'sd0, 32'd0, NO_WRITE, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SNAP_ALL, 3'd0, 16'sd0, 32'd0, FROM_PREDICTOR, 3'd0, 8'd0));
    dir_rows.push_back(mk_cmd(FUNC_SET_IMM, 3'd6, -16'sd1, 32'd0, ONE_WRITE, 3'd6, 8'd0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[k]) send_cmd(dir_rows[k], 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          ph_rate = 16'd60; ph_floor = 8'd0; ph_ceiling = 8'd180;
          ph_active = 4'd8; ph_pins = 8'hFF;
        end
        1: begin
          // floor above ceiling, fastest rate, count beyond the servo total
          ph_rate = 16'd65535; ph_floor = 8'd180; ph_ceiling = 8'd0;
          ph_active = 4'd15; ph_pins = 8'hFF;
        end
        2: begin
          ph_rate = 16'd1; ph_floor = 8'd0; ph_ceiling = 8'd180;
          ph_active = 4'd1; ph_pins = 8'h01;
        end
        3: begin
          ph_rate = 16'd1000; ph_floor = 8'd30; ph_ceiling = 8'd150;
          ph_active = 4'd0; ph_pins = 8'hA5;
        end
        default: begin
          ph_rate = 16'($urandom_range(65535, 1));
          ph_floor = 8'($urandom_range(90));
          ph_ceiling = 8'($urandom_range(180, 90));
          ph_active = 4'($urandom_range(15, 1));
          ph_pins = 8'($urandom_range(255));
        end
      endcase
      write_reg(REG_SLEW_RATE, ph_rate);
      write_reg(REG_FLOOR, {8'd0, ph_floor});
      write_reg(REG_CEILING, {8'd0, ph_ceiling});
      write_reg(REG_ACTIVE_CNT, {12'd0, ph_active});
      write_reg(REG_PIN_MASK, {8'd0, ph_pins});
      wr_en <= 1'b0;
      settings_used++;
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 76 : 20);
      counted = 0;
      while (counted < CMDS_PER_PHASE) begin
        roll_cmd(c);
        send_cmd(c, idle_pct);
        counted++;
      end
    end
    settle();

    $display("summary: %0d commands over %0d register settings plus reset defaults",
             cmds_sent, settings_used);
    $display("summary: %0d servo writes checked, %0d mismatches", writes_checked, mismatches);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
